// ----- hw/rtl/rgbc_pkg.sv -----
// Package for the 3x3 RGB convolution block: default sizes, register codes,
// the item and coefficient structs and the state types of both state machines.
// Has no dependencies; every other file of the block but rgbc_ram imports it.
package rgbc_pkg;

  localparam int unsigned MaxWidthDef   = 1024;
  localparam int unsigned PixelBitsDef  = 8;
  localparam int unsigned WeightBitsDef = 8;
  localparam int unsigned KernelSize    = 3;

  localparam int unsigned CfgAddrBits = 5;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [2:0] REG_KERNEL_BOT   = 3'd4;
  localparam logic [2:0] REG_DIVISOR      = 3'd5;
  localparam logic [2:0] REG_MAX_LEVEL    = 3'd6;

  localparam logic [10:0] FrameWidthRst  = 11'd1;
  localparam logic [12:0] FrameHeightRst = 13'd1;
  localparam logic [23:0] KernelTopRst   = 24'd0;
  localparam logic [23:0] KernelMidRst   = 24'd256;
  localparam logic [23:0] KernelBotRst   = 24'd0;
  localparam logic signed [11:0] DivisorRst = 12'sd1;
  localparam logic [7:0]  MaxLevelRst    = 8'd255;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } item_t;

  typedef struct packed {
    logic [23:0]        k_top;
    logic [23:0]        k_mid;
    logic [23:0]        k_bot;
    logic signed [11:0] divisor;
    logic [7:0]         max_level;
  } coef_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_EXEC
  } eng_state_e;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MAC,
    AR_LOAD,
    AR_DIV,
    AR_FIN,
    AR_OUT
  } ar_state_e;

endpackage

// ----- hw/rtl/rgbc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rgbc_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/rgbc_front.sv -----
// Front part: a two-word queue that takes input words and hands them to the
// step engine, so the input side keeps flowing while the back part is busy.
// Depends on rgbc_pkg.
module rgbc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rgbc_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_pop_i,
  output rgbc_pkg::item_t out_item_o
);
  import rgbc_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_pop_i && out_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ----- hw/rtl/rgbc_engine.sv -----
// Back part, stream side: tracks the raster position, keeps the two line rows
// in a RAM and the last two window columns, and issues one window per result.
// Depends on rgbc_pkg and rgbc_ram.
module rgbc_engine #(
  parameter int unsigned MaxWidth  = rgbc_pkg::MaxWidthDef,
  parameter int unsigned PixelBits = rgbc_pkg::PixelBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      restart_i,
  input  logic [10:0]               frame_width_i,
  input  logic [12:0]               frame_height_i,
  input  logic                      item_valid_i,
  input  rgbc_pkg::item_t           item_i,
  output logic                      item_pop_o,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output logic [9*3*PixelBits-1:0]  job_win_o,
  output logic                      job_last_o
);
  import rgbc_pkg::*;

  localparam int unsigned CW  = $clog2(MaxWidth);
  localparam int unsigned WW  = $clog2(MaxWidth + 1);
  localparam int unsigned PXW = 3 * PixelBits;

  eng_state_e state_q, state_d;
  logic [CW-1:0]    col_q, col_d;
  logic [13:0]      row_q, row_d;
  logic [3*PXW-1:0] win1_q, win2_q;

  logic [15:0]      fw16;
  logic [WW-1:0]    width_used;
  logic [12:0]      height_used;
  logic             inputs_done, is_pixel, take;
  logic [PXW-1:0]   pix, ls0, ls1, top, mid, bot;
  logic [2*PXW-1:0] rdata;
  logic             real_row, due, last, left_rep, ram_we;
  logic [3*PXW-1:0] abc, left_col, right_col;
  logic [WW-1:0]    col_inc;

  assign fw16 = 16'(frame_width_i);

  always_comb begin
    if (fw16 == 16'd0) begin
      width_used = WW'(1);
    end else if (fw16 > 16'(MaxWidth)) begin
      width_used = WW'(MaxWidth);
    end else begin
      width_used = WW'(fw16);
    end
    height_used = (frame_height_i == 13'd0) ? 13'd1 : frame_height_i;
  end

  assign inputs_done = (row_q >= 14'(height_used));
  assign is_pixel    = (item_i.mode == MODE_PIXEL);
  assign take        = is_pixel ? !inputs_done : inputs_done;
  assign pix = {PixelBits'(item_i.blue), PixelBits'(item_i.green), PixelBits'(item_i.red)};

  rgbc_ram #(
    .Width (2 * PXW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({bot, mid}),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  assign ls0 = rdata[PXW-1:0];
  assign ls1 = rdata[2*PXW-1:PXW];

  // Real rows replicate the top edge; virtual rows below the frame replicate
  // the bottom row.
  always_comb begin
    real_row = (row_q < 14'(height_used));
    if (real_row) begin
      bot = pix;
      mid = (row_q == 14'd0) ? pix : ls1;
      top = (row_q <= 14'd1) ? mid : ls0;
    end else begin
      top = ls0;
      mid = ls1;
      bot = ls1;
    end
    abc = {bot, mid, top};
  end

  assign due  = (row_q >= 14'd2) || ((row_q == 14'd1) && (col_q != '0));
  assign last = (row_q == 14'(height_used) + 14'd1) && (col_q == '0);

  always_comb begin
    left_rep  = (col_q == '0) ? (width_used == WW'(1)) : (col_q == CW'(1));
    left_col  = left_rep ? win2_q : win1_q;
    right_col = (col_q == '0) ? win2_q : abc;
    col_inc   = WW'(col_q) + WW'(1);
  end

  assign job_win_o  = {right_col, win2_q, left_col};
  assign job_last_o = last;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc == width_used) begin
      col_d = '0;
      row_d = row_q + 14'd1;
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: if (item_valid_i && take && job_ready_i) state_d = ENG_EXEC;
      ENG_EXEC: state_d = ENG_IDLE;
      default:  state_d = ENG_IDLE;
    endcase
  end

  // A drain step that gives no result and stays below the frame leaves the
  // word in the queue, so the next pass takes a second step.
  always_comb begin
    item_pop_o  = 1'b0;
    job_valid_o = 1'b0;
    ram_we      = 1'b0;
    unique case (state_q)
      ENG_IDLE: item_pop_o = item_valid_i && !take;
      ENG_EXEC: begin
        item_pop_o  = is_pixel || due || (row_d < 14'(height_used));
        job_valid_o = due;
        ram_we      = real_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (state_q == ENG_EXEC) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ENG_EXEC && !last) begin
      win1_q <= win2_q;
      win2_q <= abc;
    end
  end

endmodule

// ----- hw/rtl/rgbc_arith.sv -----
// Back part, arithmetic side: tap-serial multiply-accumulate for the three
// channels, bit-serial rounding divide, clamp and the output register.
// Depends on rgbc_pkg.
module rgbc_arith #(
  parameter int unsigned PixelBits  = rgbc_pkg::PixelBitsDef,
  parameter int unsigned WeightBits = rgbc_pkg::WeightBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rgbc_pkg::coef_t           coef_i,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  logic [9*3*PixelBits-1:0]  job_win_i,
  input  logic                      job_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [23:0]               out_data_o,
  output logic                      out_last_o
);
  import rgbc_pkg::*;

  localparam int unsigned PXW  = 3 * PixelBits;
  localparam int unsigned Taps = KernelSize * KernelSize;
  localparam int unsigned SW   = PixelBits + WeightBits + 5;
  localparam int unsigned NW   = (SW + 1 > 14) ? SW + 1 : 14;
  localparam int unsigned DCW  = $clog2(NW + 1);

  ar_state_e state_q, state_d;
  logic [Taps*PXW-1:0]  win_q;
  logic                 last_q;
  logic [1:0]           tap_r_q, tap_c_q;
  logic signed [SW-1:0] acc_q [3];
  logic                 sneg_q [3];
  logic [NW-1:0]        nq_q [3];
  logic [12:0]          rem_q [3];
  logic [DCW-1:0]       cnt_q;
  logic [7:0]           res_q [3];

  logic [23:0]               row24;
  logic [3*WeightBits+23:0]  row_ext;
  logic signed [WeightBits-1:0] wgt;
  logic signed [SW-1:0]      wgt_s;
  logic [3:0]                tap_sel;
  logic [PXW-1:0]            pix_sel;
  logic signed [SW-1:0]      prod [3];
  logic [11:0]               ad;
  logic [12:0]               dd;
  logic                      use_div, dneg, last_tap;
  logic [NW-1:0]             load_val [3];
  logic [13:0]               trial [3];
  logic                      qbit [3];
  logic [12:0]               rem_nx [3];
  logic [7:0]                res_nx [3];

  always_comb begin
    unique case (tap_r_q)
      2'd0:    row24 = coef_i.k_top;
      2'd1:    row24 = coef_i.k_mid;
      default: row24 = coef_i.k_bot;
    endcase
    row_ext = {{(3*WeightBits){1'b0}}, row24};
    wgt     = $signed(row_ext[tap_c_q*WeightBits +: WeightBits]);
    wgt_s   = SW'(wgt);
    tap_sel = 4'(tap_c_q * 3 + tap_r_q);
    pix_sel = win_q[tap_sel*PXW +: PXW];
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = SW'($signed({1'b0, pix_sel[ch*PixelBits +: PixelBits]})) * wgt_s;
    end
  end

  assign last_tap = (tap_r_q == 2'd2) && (tap_c_q == 2'd2);
  assign use_div  = (coef_i.divisor != 12'sd0);
  assign dneg     = coef_i.divisor[11];
  assign ad       = dneg ? unsigned'(-coef_i.divisor) : unsigned'(coef_i.divisor);
  assign dd       = {ad, 1'b0};

  // The rounded quotient is (2|s| + |d|) / (2|d|); without a divisor the
  // magnitude passes straight through.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [SW-1:0] mag;
      mag = acc_q[ch][SW-1] ? unsigned'(-acc_q[ch]) : unsigned'(acc_q[ch]);
      load_val[ch] = use_div ? (NW'({mag, 1'b0}) + NW'(ad)) : NW'(mag);
      trial[ch]    = {rem_q[ch], nq_q[ch][NW-1]};
      qbit[ch]     = (trial[ch] >= 14'(dd));
      rem_nx[ch]   = qbit[ch] ? 13'(trial[ch] - 14'(dd)) : trial[ch][12:0];
      if (use_div ? (sneg_q[ch] != dneg) : sneg_q[ch]) begin
        res_nx[ch] = 8'd0;
      end else if (nq_q[ch] > NW'(coef_i.max_level)) begin
        res_nx[ch] = coef_i.max_level;
      end else begin
        res_nx[ch] = 8'(nq_q[ch]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AR_IDLE: if (job_valid_i) state_d = AR_MAC;
      AR_MAC:  if (last_tap) state_d = AR_LOAD;
      AR_LOAD: state_d = use_div ? AR_DIV : AR_FIN;
      AR_DIV:  if (cnt_q == DCW'(NW - 1)) state_d = AR_FIN;
      AR_FIN:  state_d = AR_OUT;
      AR_OUT:  if (out_ready_i) state_d = AR_IDLE;
      default: state_d = AR_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == AR_IDLE);
    out_valid_o = (state_q == AR_OUT);
    out_data_o  = {res_q[2], res_q[1], res_q[0]};
    out_last_o  = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      AR_IDLE: begin
        win_q   <= job_win_i;
        last_q  <= job_last_i;
        tap_r_q <= 2'd0;
        tap_c_q <= 2'd0;
        for (int ch = 0; ch < 3; ch++) acc_q[ch] <= '0;
      end
      AR_MAC: begin
        for (int ch = 0; ch < 3; ch++) acc_q[ch] <= acc_q[ch] + prod[ch];
        if (tap_c_q == 2'd2) begin
          tap_c_q <= 2'd0;
          tap_r_q <= tap_r_q + 2'd1;
        end else begin
          tap_c_q <= tap_c_q + 2'd1;
        end
      end
      AR_LOAD: begin
        cnt_q <= '0;
        for (int ch = 0; ch < 3; ch++) begin
          nq_q[ch]   <= load_val[ch];
          rem_q[ch]  <= '0;
          sneg_q[ch] <= acc_q[ch][SW-1];
        end
      end
      AR_DIV: begin
        cnt_q <= cnt_q + DCW'(1);
        for (int ch = 0; ch < 3; ch++) begin
          rem_q[ch] <= rem_nx[ch];
          nq_q[ch]  <= {nq_q[ch][NW-2:0], qbit[ch]};
        end
      end
      AR_FIN: begin
        for (int ch = 0; ch < 3; ch++) res_q[ch] <= res_nx[ch];
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/rgb_convolution_3x3_clamped.sv -----
// Top level of the 3x3 RGB convolution: configuration registers, input queue,
// step engine with line RAM, and the arithmetic back end.
// Depends on rgbc_pkg, rgbc_front, rgbc_engine and rgbc_arith.
//
// Usage: pixels enter in raster order on the s_axis channel with tuser low;
// after the last pixel of a frame, words with tuser high drain the remaining
// results. Results leave on m_axis in raster order, tlast on the final pixel.
// A result for a pixel is produced once frame_width+1 further words have been
// taken, since the window needs the row below.
// Each word passes the step engine's idle and exec states (line RAM read, then
// update), and the engine only steps a word while the arithmetic unit is idle.
// A word that yields a result holds the arithmetic unit through its states in
// order: issue, tap-serial multiply-accumulate over the nine taps, a load, the
// bit-serial divider at one quotient bit per cycle (skipped when the divisor
// is 0), a clamp and the output until m_axis takes it. The arithmetic unit
// takes no new window until the previous result has left on m_axis.
// A two-word input queue keeps accepting while a result waits on m_axis; when
// the receiver stalls, the engine halts at the next word it must step and
// input back-pressure follows once the queue is full.
// Reset clears the position, empties the queue and loads the register
// defaults; writing frame_width or frame_height restarts the frame.
module rgb_convolution_3x3_clamped #(
  parameter int unsigned MaxWidth   = rgbc_pkg::MaxWidthDef,
  parameter int unsigned PixelBits  = rgbc_pkg::PixelBitsDef,
  parameter int unsigned WeightBits = rgbc_pkg::WeightBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                             s_axis_tuser,  // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // red_out, green_out, blue_out
  output logic                             m_axis_tlast,  // last_of_frame
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbc_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rgbc_pkg::*;

  logic [10:0]        fw_q;
  logic [12:0]        fh_q;
  logic [23:0]        kt_q, km_q, kb_q;
  logic signed [11:0] div_q;
  logic [7:0]         max_q;
  logic               cfg_wr, restart;
  logic [2:0]         reg_idx;
  coef_t              coef;

  item_t in_item, q_item;
  logic  q_valid, q_pop;
  logic  job_valid, job_ready, job_last;
  logic [9*3*PixelBits-1:0] job_win;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && ((reg_idx == REG_FRAME_WIDTH) || (reg_idx == REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FrameWidthRst;
      fh_q  <= FrameHeightRst;
      kt_q  <= KernelTopRst;
      km_q  <= KernelMidRst;
      kb_q  <= KernelBotRst;
      div_q <= DivisorRst;
      max_q <= MaxLevelRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  fw_q  <= pwdata[10:0];
        REG_FRAME_HEIGHT: fh_q  <= pwdata[12:0];
        REG_KERNEL_TOP:   kt_q  <= pwdata[23:0];
        REG_KERNEL_MID:   km_q  <= pwdata[23:0];
        REG_KERNEL_BOT:   kb_q  <= pwdata[23:0];
        REG_DIVISOR:      div_q <= $signed(pwdata[11:0]);
        REG_MAX_LEVEL:    max_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {21'd0, fw_q};
      REG_FRAME_HEIGHT: prdata = {19'd0, fh_q};
      REG_KERNEL_TOP:   prdata = {8'd0, kt_q};
      REG_KERNEL_MID:   prdata = {8'd0, km_q};
      REG_KERNEL_BOT:   prdata = {8'd0, kb_q};
      REG_DIVISOR:      prdata = {20'd0, div_q};
      REG_MAX_LEVEL:    prdata = {24'd0, max_q};
      default:          prdata = 32'd0;
    endcase
  end

  assign coef = '{k_top: kt_q, k_mid: km_q, k_bot: kb_q, divisor: div_q, max_level: max_q};
  assign in_item = '{mode: s_axis_tuser, blue: s_axis_tdata[23:16],
                     green: s_axis_tdata[15:8], red: s_axis_tdata[7:0]};

  rgbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_pop_i   (q_pop),
    .out_item_o  (q_item)
  );

  rgbc_engine #(
    .MaxWidth  (MaxWidth),
    .PixelBits (PixelBits)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .frame_width_i  (fw_q),
    .frame_height_i (fh_q),
    .item_valid_i   (q_valid),
    .item_i         (q_item),
    .item_pop_o     (q_pop),
    .job_valid_o    (job_valid),
    .job_ready_i    (job_ready),
    .job_win_o      (job_win),
    .job_last_o     (job_last)
  );

  rgbc_arith #(
    .PixelBits  (PixelBits),
    .WeightBits (WeightBits)
  ) u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_win_i   (job_win),
    .job_last_i  (job_last),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/sv/rgbc_checker.sv -----
// Checker for the 3x3 RGB convolution: watches the pixel, result and register
// channels, predicts each result from its own model of the window and line
// stores, and compares it with what leaves the block. Depends on rgbc_pkg.
module rgbc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [23:0]                      m_axis_tdata,
  input  logic                             m_axis_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbc_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  input  logic                             pready,
  output int                               fail_cnt_o,
  output int                               pending_o,
  output int                               result_cnt_o
);
  import rgbc_pkg::*;

  typedef struct packed {
    logic       last;
    logic [23:0] pix;
  } result_t;

  // Shadow copy of the registers.
  logic [10:0]        width_q;
  logic [12:0]        height_q;
  logic [23:0]        krow [3];
  logic signed [11:0] div_q;
  logic [7:0]         maxlvl_q;

  logic [23:0] rows_store [2][MaxWidthDef];
  logic [23:0] win [3][3];  // [column, 0 oldest][row, 0 top]
  int          col_pos, row_pos, emitted;

  result_t expected_px [$];

  function automatic int frame_w();
    if (width_q < 1) return 1;
    if (width_q > MaxWidthDef) return MaxWidthDef;
    return int'(width_q);
  endfunction

  function automatic int frame_h();
    return (height_q < 1) ? 1 : int'(height_q);
  endfunction

  function automatic logic [7:0] filter_channel(int ch, int cl, int cm, int cr);
    longint s, as, ad, q, d;
    int cols [3];
    logic signed [7:0] wt;
    s = 0;
    cols[0] = cl; cols[1] = cm; cols[2] = cr;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wt = krow[r][8*c +: 8];
        s += longint'(win[cols[c]][r][8*ch +: 8]) * longint'(wt);
      end
    end
    if (div_q != 0) begin
      d  = longint'(div_q);
      as = (s < 0) ? -s : s;
      ad = (d < 0) ? -d : d;
      q  = (2 * as + ad) / (2 * ad);
      s  = ((s < 0) != (d < 0)) ? -q : q;
    end
    if (s < 0) return 8'd0;
    if (s > longint'(maxlvl_q)) return maxlvl_q;
    return s[7:0];
  endfunction

  function automatic void push_result(int cl, int cm, int cr);
    result_t res;
    int total;
    total = frame_w() * frame_h();
    for (int ch = 0; ch < 3; ch++) res.pix[8*ch +: 8] = filter_channel(ch, cl, cm, cr);
    res.last = (emitted + 1 == total);
    expected_px = {expected_px, res};
    emitted++;
    if (emitted >= total) begin
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
    end
  endfunction

  // One position step; on a virtual row (below the frame) the pixel is unused.
  function automatic bit walk_position(logic [23:0] pix);
    int w, h, ir, ic;
    bit due;
    logic [23:0] a, b, c;
    w  = frame_w();
    h  = frame_h();
    ir = row_pos;
    ic = col_pos;
    due = (longint'(ir) * w + ic) >= w + 1;
    if (ir < h) begin
      c = pix;
      b = (ir == 0) ? c : rows_store[1][ic];
      a = (ir <= 1) ? b : rows_store[0][ic];
      rows_store[0][ic] = b;
      rows_store[1][ic] = c;
    end else begin
      a = rows_store[0][ic];
      b = rows_store[1][ic];
      c = b;
    end
    if (ic == 0) begin
      if (due) push_result((w == 1) ? 2 : 1, 2, 2);
      if (due && row_pos == 0 && emitted == 0) return 1'b1;
      if (ir <= h) begin
        win[0] = win[1]; win[1] = win[2];
        win[2][0] = a; win[2][1] = b; win[2][2] = c;
      end
    end else begin
      win[0] = win[1]; win[1] = win[2];
      win[2][0] = a; win[2][1] = b; win[2][2] = c;
      if (due) push_result((ic == 1) ? 1 : 0, 1, 2);
      if (due && row_pos == 0 && emitted == 0) return 1'b1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    return due;
  endfunction

  function automatic void take_word(logic mode, logic [23:0] pix);
    bit inputs_done;
    inputs_done = row_pos >= frame_h();
    if (mode == MODE_PIXEL) begin
      if (!inputs_done) void'(walk_position(pix));
    end else if (inputs_done) begin
      // A drain step that gives no result and stays below the frame steps again.
      if (!walk_position('0) && row_pos >= frame_h())
        void'(walk_position('0));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_px;
    logic [2:0] idx;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
      krow[0]  <= KernelTopRst;
      krow[1]  <= KernelMidRst;
      krow[2]  <= KernelBotRst;
      div_q    <= DivisorRst;
      maxlvl_q <= MaxLevelRst;
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
      for (int i = 0; i < MaxWidthDef; i++) begin
        rows_store[0][i] = '0;
        rows_store[1][i] = '0;
      end
      col_pos = 0; row_pos = 0; emitted = 0;
      expected_px.delete();
      fail_cnt_o   <= 0;
      result_cnt_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt_o <= result_cnt_o + 1;
        if (expected_px.size() == 0) begin
          $error("unexpected result word: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          exp_px = expected_px.pop_front();
          if (m_axis_tdata[7:0] !== exp_px.pix[7:0]) begin
            $error("red_out: expected %0d, got %0d", exp_px.pix[7:0], m_axis_tdata[7:0]);
            errs++;
          end
          if (m_axis_tdata[15:8] !== exp_px.pix[15:8]) begin
            $error("green_out: expected %0d, got %0d", exp_px.pix[15:8], m_axis_tdata[15:8]);
            errs++;
          end
          if (m_axis_tdata[23:16] !== exp_px.pix[23:16]) begin
            $error("blue_out: expected %0d, got %0d", exp_px.pix[23:16], m_axis_tdata[23:16]);
            errs++;
          end
          if (m_axis_tlast !== exp_px.last) begin
            $error("last_of_frame: expected %b, got %b", exp_px.last, m_axis_tlast);
            errs++;
          end
        end
        if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      end
      if (s_axis_tvalid && s_axis_tready) take_word(s_axis_tuser, s_axis_tdata);
      if (psel && penable && pwrite && pready) begin
        idx = paddr[4:2];
        case (idx)
          REG_FRAME_WIDTH:  width_q  <= pwdata[10:0];
          REG_FRAME_HEIGHT: height_q <= pwdata[12:0];
          REG_KERNEL_TOP:   krow[0]  <= pwdata[23:0];
          REG_KERNEL_MID:   krow[1]  <= pwdata[23:0];
          REG_KERNEL_BOT:   krow[2]  <= pwdata[23:0];
          REG_DIVISOR:      div_q    <= pwdata[11:0];
          REG_MAX_LEVEL:    maxlvl_q <= pwdata[7:0];
          default: ;
        endcase
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
          col_pos = 0; row_pos = 0; emitted = 0;
        end
      end
    end
  end

  assign pending_o = expected_px.size();

endmodule

// ----- tb/sv/tb_rgb_convolution_3x3_clamped.sv -----
// Testbench top for the 3x3 RGB convolution: clock, reset, register writes,
// pixel and drain words with random gaps and receiver stalls, and the verdict.
// Depends on rgbc_pkg, rgbc_checker and the block itself.
module tb_rgb_convolution_3x3_clamped;
  import rgbc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // red_in, green_in, blue_in
  logic        s_axis_tuser = 1'b0;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // red_out, green_out, blue_out
  logic        m_axis_tlast;  // last_of_frame
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_cnt, pending, result_cnt;
  int words_sent = 0;
  int frames_run = 0;
  bit calm = 1'b0;       // no idling on either side
  bit hold_req = 1'b0;   // asks the receiver for one long stall

  always #1 clk_i = ~clk_i;

  rgb_convolution_3x3_clamped u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rgbc_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrBits'(idx) << 2;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_word(logic mode, logic [23:0] pix);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Lets the block hand out all expected results and finish words that cause no result before a register write.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic configure(logic [10:0] w, logic [12:0] h, logic [23:0] kt, logic [23:0] km,
                           logic [23:0] kb, logic signed [11:0] dv, logic [7:0] ml);
    settle();
    reg_write(REG_FRAME_WIDTH, 32'(w));
    reg_write(REG_FRAME_HEIGHT, 32'(h));
    reg_write(REG_KERNEL_TOP, 32'(kt));
    reg_write(REG_KERNEL_MID, 32'(km));
    reg_write(REG_KERNEL_BOT, 32'(kb));
    reg_write(REG_DIVISOR, 32'(dv));
    reg_write(REG_MAX_LEVEL, 32'(ml));
  endtask

  // One frame of random pixels; noise adds stray drains and stray pixels.
  task automatic run_frame(int w, int h, bit noisy, bit partial);
    int npix;
    npix = partial ? $urandom_range(1, w * h - 1) : w * h;
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 31) == 0) send_word(MODE_DRAIN, 24'($urandom));
      send_word(MODE_PIXEL, 24'($urandom));
    end
    if (partial) return;
    if (noisy && $urandom_range(0, 4) == 0) send_word(MODE_PIXEL, 24'($urandom));
    for (int i = 0; i < w + 1; i++) send_word(MODE_DRAIN, 24'($urandom));
    if (noisy && $urandom_range(0, 3) == 0) send_word(MODE_DRAIN, '0);
    frames_run++;
  endtask

  function automatic logic signed [11:0] pick_divisor();
    case ($urandom_range(0, 5))
      0: return 12'sd0;
      1: return -12'sd1152;
      2: return 12'sd1152;
      3: return 12'sd1;
      default: return 12'($signed($urandom_range(0, 2304)) - 1152);
    endcase
  endfunction

  // Receiver: random stalls in bursts, calm stretches, one long hold-off.
  initial begin
    bit hold_done;
    int stall_odds;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      stall_odds = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk_i);
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (600) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end else if (!calm && stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 16)) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("** rgb_convolution_3x3_clamped: FAILED **");
    $finish;
  end

  initial begin
    int w, h;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frame: extreme channel values, a negative kernel, a stray drain
    // before the end, a stray pixel after it and a drain with nothing pending.
    configure(11'd4, 13'd3, 24'hFF_00_01, 24'h02_7F_80, 24'h01_00_FF, 12'sd3, 8'd255);
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_word(MODE_DRAIN, 24'hFFFFFF);
      send_word(MODE_PIXEL, (i % 2) ? 24'hFFFFFF : ((i % 3) ? 24'h00FF00 : 24'h000000));
    end
    send_word(MODE_PIXEL, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_word(MODE_DRAIN, '0);

    // Edge sizes: register zero clamps to one, oversize width clamps down.
    configure(11'd0, 13'd0, 24'h00_00_00, 24'h00_01_00, 24'h00_00_00, 12'sd1, 8'd1);
    run_frame(1, 1, 1'b0, 1'b0);
    configure(11'd1, 13'd20, 24'h01_01_01, 24'h01_F8_01, 24'h01_01_01, 12'sd0, 8'd255);
    run_frame(1, 20, 1'b1, 1'b0);
    // The clamped frame stops six pixels into its second row, after its first
    // results; the next size write restarts it.
    configure(11'd2047, 13'd2, 24'($urandom), 24'($urandom), 24'($urandom), -12'sd1152, 8'd128);
    for (int i = 0; i < MaxWidthDef + 6; i++) send_word(MODE_PIXEL, 24'($urandom));

    // Long receiver hold-off while pixels keep coming.
    configure(11'd6, 13'd5, 24'h01_02_01, 24'h02_04_02, 24'h01_02_01, 12'sd16, 8'd255);
    hold_req = 1'b1;
    run_frame(6, 5, 1'b0, 1'b0);

    while (words_sent < 1550) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      calm = (words_sent > 1300);
      configure(11'(w), 13'(h), 24'($urandom), 24'($urandom), 24'($urandom),
                pick_divisor(), ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 255)));
      run_frame(w, h, 1'b1, (w * h > 1) && $urandom_range(0, 15) == 0);
      if ($urandom_range(0, 5) == 0) run_frame(w, h, 1'b1, 1'b0);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Run covered %0d words over %0d frames, %0d result words checked.",
             words_sent, frames_run, result_cnt);
    if (fail_cnt == 0) begin
      $display("** rgb_convolution_3x3_clamped: PASSED **");
    end else begin
      $display("** rgb_convolution_3x3_clamped: FAILED **");
    end
    $finish;
  end

endmodule
